### src/pts_pkg.sv
// Shared types, constants and helpers for the polynomial trajectory sampler.
// Used by the divider stage, the Horner step and the top level. No dependencies.
package pts_pkg;

  // Configuration register indexes; indexes above the last one are ignored
  localparam logic [3:0] REG_START   = 4'd0;
  localparam logic [3:0] REG_END     = 4'd1;
  localparam logic [3:0] REG_SECTION = 4'd2;
  localparam logic [3:0] REG_TERMS   = 4'd3;
  localparam logic [3:0] REG_COEF_A  = 4'd4;
  localparam logic [3:0] REG_COEF_B  = 4'd5;
  localparam logic [3:0] REG_COEF_C  = 4'd6;
  localparam logic [3:0] REG_COEF_D  = 4'd7;

  // Number of coefficient registers
  localparam int COEF_REGS  = 4;

  // Time divider: 33 quotient bits, three per stage
  localparam int QUOT_W     = 33;
  localparam int DIV_BITS   = 3;
  localparam int DIV_STAGES = QUOT_W / DIV_BITS;
  localparam int SEC_W      = 16;
  localparam int PROD_W     = SEC_W + QUOT_W;

  // Which accumulators a Horner step updates
  typedef struct packed {
    logic pos;
    logic vel;
  } pts_act_t;

  // Clamp a wide signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [49:0] hi;
    logic signed [49:0] lo;
    hi = 50'sh0_0000_7FFF_FFFF;
    lo = -50'sh0_0000_8000_0000;
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

### src/polynomial_trajectory_sampler.sv
// Top level of the polynomial trajectory sampler: configuration registers,
// index clamp, time scaling pipeline and Horner chain. Depends on pts_pkg,
// pts_div_stage and pts_horner_step.

// Accepts one sample index per clock while in_ready is high and returns one
// result per index, in order. Registers in order: index clamp, index-by-span
// multiply, eleven time divider stages (three quotient bits each), start time
// add, then two per Horner step for three steps (multiply, shift-add-saturate).
// The whole pipeline advances together whenever the output register is empty
// or being taken, so in_ready is low only while a result waits at the output.
// Configuration must be written only while no transaction is in flight, which
// the block does not enforce; it takes effect on the next accepted index.
module polynomial_trajectory_sampler
  import pts_pkg::*;
#(
  parameter int MAX_TERMS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        sample_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] sample_time,
  output logic signed [31:0] position_out,
  output logic signed [31:0] velocity_out
);

  localparam int TERM_CAP = (MAX_TERMS < COEF_REGS) ? MAX_TERMS : COEF_REGS;
  localparam int STEPS    = COEF_REGS - 1;

  // Configuration registers
  logic signed [31:0] start_time;
  logic signed [31:0] end_time;
  logic [SEC_W-1:0]   section_count;
  logic [2:0]         term_count;
  logic signed [31:0] coef [COEF_REGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      start_time    <= '0;
      end_time      <= 32'sd65536;
      section_count <= SEC_W'(1);
      term_count    <= 3'd1;
      for (int k = 0; k < COEF_REGS; k++) begin
        coef[k] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START:   start_time    <= cfg_data;
        REG_END:     end_time      <= cfg_data;
        REG_SECTION: section_count <= cfg_data[SEC_W-1:0];
        REG_TERMS:   term_count    <= cfg_data[2:0];
        REG_COEF_A:  coef[0]       <= cfg_data;
        REG_COEF_B:  coef[1]       <= cfg_data;
        REG_COEF_C:  coef[2]       <= cfg_data;
        REG_COEF_D:  coef[3]       <= cfg_data;
        default:     ;
      endcase
    end
  end

  // Static values derived from configuration
  logic [SEC_W-1:0]   secs;
  logic [2:0]         terms;
  logic signed [32:0] span;
  logic               span_neg;
  logic [QUOT_W-1:0]  span_mag;
  logic signed [31:0] dcoef [COEF_REGS];

  assign secs     = (section_count == '0) ? SEC_W'(1) : section_count;
  assign span     = $signed({end_time[31], end_time}) - $signed({start_time[31], start_time});
  assign span_neg = span[32];
  assign span_mag = span_neg ? QUOT_W'(-span) : QUOT_W'(span);

  always_comb begin
    if (term_count == 3'd0) begin
      terms = 3'd1;
    end else if (term_count > 3'(TERM_CAP)) begin
      terms = 3'(TERM_CAP);
    end else begin
      terms = term_count;
    end
  end

  // Derivative coefficients: scale by the remaining power, then saturate
  always_comb begin
    logic [2:0]         mult;
    logic signed [33:0] ext;
    logic signed [33:0] scaled;
    for (int k = 0; k < COEF_REGS; k++) begin
      mult = (3'(k + 1) < terms) ? (terms - 3'(k + 1)) : 3'd0;
      ext  = $signed({{2{coef[k][31]}}, coef[k]});
      unique case (mult[1:0])
        2'd0:    scaled = '0;
        2'd1:    scaled = ext;
        2'd2:    scaled = ext <<< 1;
        default: scaled = ext + (ext <<< 1);
      endcase
      dcoef[k] = sat32($signed({{16{scaled[33]}}, scaled}));
    end
  end

  // Global advance: move when the output register is free or being taken
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Clamp stage
  logic             v0;
  logic [SEC_W-1:0] idx0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
    end
    if (adv) begin
      idx0 <= (sample_index > secs) ? secs : sample_index;
    end
  end

  // Index by span magnitude
  logic              v1;
  logic [PROD_W-1:0] prod1;
  logic              neg1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= v0;
    end
    if (adv) begin
      prod1 <= PROD_W'(idx0) * PROD_W'(span_mag);
      neg1  <= span_neg;
    end
  end

  // Divider chain
  logic              dv   [DIV_STAGES+1];
  logic [SEC_W-1:0]  drem [DIV_STAGES+1];
  logic [QUOT_W-1:0] dword[DIV_STAGES+1];
  logic              dneg [DIV_STAGES+1];

  assign dv[0]    = v1;
  assign drem[0]  = prod1[PROD_W-1:QUOT_W];
  assign dword[0] = prod1[QUOT_W-1:0];
  assign dneg[0]  = neg1;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    pts_div_stage u_div (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .divisor  (secs),
      .in_valid (dv[g]),
      .in_rem   (drem[g]),
      .in_word  (dword[g]),
      .in_neg   (dneg[g]),
      .out_valid(dv[g+1]),
      .out_rem  (drem[g+1]),
      .out_word (dword[g+1]),
      .out_neg  (dneg[g+1])
    );
  end

  // Sample time: start plus the signed quotient
  logic               vt;
  logic signed [31:0] tt;
  logic signed [33:0] quot_s;
  logic signed [33:0] time_sum;

  assign quot_s   = dneg[DIV_STAGES] ? -$signed({1'b0, dword[DIV_STAGES]})
                                     : $signed({1'b0, dword[DIV_STAGES]});
  assign time_sum = $signed({{2{start_time[31]}}, start_time}) + quot_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      vt <= 1'b0;
    end else if (adv) begin
      vt <= dv[DIV_STAGES];
    end
    if (adv) begin
      tt <= time_sum[31:0];
    end
  end

  // Horner chain, seeded with the leading coefficients
  logic               hv  [STEPS+1];
  logic signed [31:0] ht  [STEPS+1];
  logic signed [31:0] hpos[STEPS+1];
  logic signed [31:0] hvel[STEPS+1];

  assign hv[0]   = vt;
  assign ht[0]   = tt;
  assign hpos[0] = coef[0];
  assign hvel[0] = dcoef[0];

  for (genvar s = 1; s <= STEPS; s++) begin : g_horner
    pts_act_t act;
    assign act.pos = 3'(s) < terms;
    assign act.vel = 3'(s + 1) < terms;

    pts_horner_step u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .act      (act),
      .coef_pos (coef[s]),
      .coef_vel (dcoef[s]),
      .in_valid (hv[s-1]),
      .in_t     (ht[s-1]),
      .in_pos   (hpos[s-1]),
      .in_vel   (hvel[s-1]),
      .out_valid(hv[s]),
      .out_t    (ht[s]),
      .out_pos  (hpos[s]),
      .out_vel  (hvel[s])
    );
  end

  assign out_valid    = hv[STEPS];
  assign sample_time  = ht[STEPS];
  assign position_out = hpos[STEPS];
  assign velocity_out = hvel[STEPS];

  // Checks
  logic signed [31:0] t_lo;
  logic signed [31:0] t_hi;
  assign t_lo = (start_time < end_time) ? start_time : end_time;
  assign t_hi = (start_time < end_time) ? end_time : start_time;

  // Sample time stays between start and end
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sample_time >= t_lo && sample_time <= t_hi))
    else $error("sample time outside trajectory span");

  // Divider remainder stays below the section count
  assert property (@(posedge clk) disable iff (rst)
    dv[DIV_STAGES] |-> (drem[DIV_STAGES] < secs))
    else $error("divider remainder not below section count");

  // Constant polynomial gives zero velocity
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && terms == 3'd1) |-> (velocity_out == '0))
    else $error("nonzero velocity for constant polynomial");

  // Nothing comes out right after reset
  assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

### src/pts_div_stage.sv
// One pipeline stage of the restoring divider that scales the sample time.
// Retires DIV_BITS quotient bits per cycle while en is high. Depends on pts_pkg.
module pts_div_stage
  import pts_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic [SEC_W-1:0]  divisor,
  input  logic              in_valid,
  input  logic [SEC_W-1:0]  in_rem,
  input  logic [QUOT_W-1:0] in_word,
  input  logic              in_neg,
  output logic              out_valid,
  output logic [SEC_W-1:0]  out_rem,
  output logic [QUOT_W-1:0] out_word,
  output logic              out_neg
);

  logic [SEC_W-1:0]  rem_next;
  logic [QUOT_W-1:0] word_next;

  // Shift in dividend bits, subtract when the partial remainder allows
  always_comb begin
    logic [SEC_W:0] trial;
    rem_next  = in_rem;
    word_next = in_word;
    for (int j = 0; j < DIV_BITS; j++) begin
      trial     = {rem_next, word_next[QUOT_W-1]};
      word_next = {word_next[QUOT_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        trial        = trial - {1'b0, divisor};
        word_next[0] = 1'b1;
      end
      rem_next = trial[SEC_W-1:0];
    end
  end

  // Advance the stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_rem  <= rem_next;
      out_word <= word_next;
      out_neg  <= in_neg;
    end
  end

endmodule

### src/pts_horner_step.sv
// One Horner step for position and velocity: register the products, then
// shift, add the coefficient and saturate. Depends on pts_pkg.
module pts_horner_step
  import pts_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  pts_act_t           act,
  input  logic signed [31:0] coef_pos,
  input  logic signed [31:0] coef_vel,
  input  logic               in_valid,
  input  logic signed [31:0] in_t,
  input  logic signed [31:0] in_pos,
  input  logic signed [31:0] in_vel,
  output logic               out_valid,
  output logic signed [31:0] out_t,
  output logic signed [31:0] out_pos,
  output logic signed [31:0] out_vel
);

  logic               mul_valid;
  logic signed [31:0] mul_t;
  logic signed [31:0] mul_pos;
  logic signed [31:0] mul_vel;
  logic signed [63:0] prod_pos;
  logic signed [63:0] prod_vel;
  logic signed [49:0] sum_pos;
  logic signed [49:0] sum_vel;

  // Floor of product / 2^16 plus the coefficient
  assign sum_pos = $signed({{2{prod_pos[63]}}, prod_pos[63:16]})
                 + $signed({{18{coef_pos[31]}}, coef_pos});
  assign sum_vel = $signed({{2{prod_vel[63]}}, prod_vel[63:16]})
                 + $signed({{18{coef_vel[31]}}, coef_vel});

  // Multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (en) begin
      mul_valid <= in_valid;
    end
    if (en) begin
      mul_t    <= in_t;
      mul_pos  <= in_pos;
      mul_vel  <= in_vel;
      prod_pos <= in_pos * in_t;
      prod_vel <= in_vel * in_t;
    end
  end

  // Accumulate stage; hold the accumulator where this step is not in use
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= mul_valid;
    end
    if (en) begin
      out_t   <= mul_t;
      out_pos <= act.pos ? sat32(sum_pos) : mul_pos;
      out_vel <= act.vel ? sat32(sum_vel) : mul_vel;
    end
  end

endmodule

### verif/tb_top.sv
// Testbench for polynomial_trajectory_sampler: directed and random sample indexes
// checked against an in-bench Q16.16 Horner predictor. Depends on pts_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top;
  import pts_pkg::*;

  localparam int MAX_TERMS = 4;
  localparam int LATENCY   = 20;

  typedef struct {
    logic signed [31:0] t;
    logic signed [31:0] pos;
    logic signed [31:0] vel;
  } sample_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [3:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [15:0]        sample_index;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] sample_time;
  logic signed [31:0] position_out;
  logic signed [31:0] velocity_out;

  // Shadow copy of the register file
  logic signed [31:0] m_start;
  logic signed [31:0] m_end;
  logic [15:0]        m_sections;
  logic [2:0]         m_terms;
  logic signed [31:0] m_coef [COEF_REGS];

  sample_t expected_samples [$];
  int      error_count;
  bit      stall_enable;

  polynomial_trajectory_sampler #(.MAX_TERMS(MAX_TERMS)) DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .sample_index(sample_index),
    .out_valid(out_valid), .out_ready(out_ready), .sample_time(sample_time),
    .position_out(position_out), .velocity_out(velocity_out)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Q16.16 multiply, rounding toward minus infinity
  function automatic longint q_mul(input longint a, input longint b);
    return (a * b) >>> 16;
  endfunction

  function automatic longint horner_eval(input longint c [COEF_REGS], input int n,
                                         input longint t);
    longint acc;
    acc = c[0];
    for (int k = 1; k < n; k++) acc = clamp32(q_mul(acc, t) + c[k]);
    return acc;
  endfunction

  function automatic sample_t predict_sample(input logic [15:0] idx_in);
    longint secs, idx, t, span;
    longint c [COEF_REGS];
    longint dc [COEF_REGS];
    int n, cap;
    sample_t s;
    secs = (m_sections == 0) ? 1 : m_sections;
    idx = idx_in;
    if (idx > secs) idx = secs;
    span = longint'(m_end) - longint'(m_start);
    t = longint'(m_start) + (idx * span) / secs;
    cap = (MAX_TERMS < COEF_REGS) ? MAX_TERMS : COEF_REGS;
    n = m_terms;
    if (n < 1) n = 1;
    if (n > cap) n = cap;
    for (int k = 0; k < COEF_REGS; k++) begin
      c[k] = m_coef[k];
      dc[k] = 0;
    end
    s.t = t[31:0];
    s.pos = 32'(horner_eval(c, n, t));
    if (n <= 1) begin
      s.vel = '0;
    end else begin
      for (int k = 0; k + 1 < n; k++) dc[k] = clamp32(c[k] * (n - 1 - k));
      s.vel = 32'(horner_eval(dc, n - 1, t));
    end
    return s;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic int gap_len();
    if (!stall_enable) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(5, 30);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Write one register while the pipeline is empty
  task automatic write_reg(input logic [3:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_START:   m_start = val;
      REG_END:     m_end = val;
      REG_SECTION: m_sections = val[15:0];
      REG_TERMS:   m_terms = val[2:0];
      REG_COEF_A:  m_coef[0] = val;
      REG_COEF_B:  m_coef[1] = val;
      REG_COEF_C:  m_coef[2] = val;
      REG_COEF_D:  m_coef[3] = val;
      default:     ;
    endcase
  endtask

  // Drop valid, then wait until every expected result has come back
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic load_config(input logic [31:0] st, input logic [31:0] en,
                             input logic [15:0] sec, input logic [2:0] nt,
                             input logic [31:0] a, input logic [31:0] b,
                             input logic [31:0] c, input logic [31:0] d);
    wait_drain();
    write_reg(REG_START, st);
    write_reg(REG_END, en);
    write_reg(REG_SECTION, {16'd0, sec});
    write_reg(REG_TERMS, {29'd0, nt});
    write_reg(REG_COEF_A, a);
    write_reg(REG_COEF_B, b);
    write_reg(REG_COEF_C, c);
    write_reg(REG_COEF_D, d);
  endtask

  // Send one index transaction; expectation is queued at acceptance.
  // Valid stays high after acceptance unless a gap follows.
  task automatic send_index(input logic [15:0] idx);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_samples.insert(expected_samples.size(), predict_sample(idx));
  endtask

  // Stall the result side at random
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (!stall_enable) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    sample_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_samples.size() == 0) begin
        $display("MISMATCH: unexpected result at %0t", $realtime);
        error_count++;
      end else begin
        want = expected_samples.pop_front();
        if (sample_time !== want.t) report_mismatch("sample_time", sample_time, want.t);
        if (position_out !== want.pos)
          report_mismatch("position_out", position_out, want.pos);
        if (velocity_out !== want.vel)
          report_mismatch("velocity_out", velocity_out, want.vel);
      end
    end
  end

  task automatic test_reset_defaults();
    send_index(16'd0);
    send_index(16'd1);
    send_index(16'hFFFF);
  endtask

  task automatic test_directed_extremes();
    // cubic with extreme coefficients, index clamp and saturation
    load_config(32'h8000_0000, 32'h7FFF_FFFF, 16'd3, 3'd4,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    for (int i = 0; i < 5; i++) send_index(16'(i));
    send_index(16'hFFFF);
    // zero sections and zero terms
    load_config(32'h0001_0000, 32'hFFFF_0000, 16'd0, 3'd0,
                32'h0002_0000, 0, 0, 0);
    send_index(16'd0);
    send_index(16'd1);
    send_index(16'd2);
    // too many terms, constant polynomial, max sections
    load_config(32'h0000_0000, 32'h0004_0000, 16'hFFFF, 3'd7,
                32'h0000_8000, 32'hFFFF_0000, 32'h0003_0000, 32'h1234_5678);
    send_index(16'd0);
    send_index(16'h8000);
    send_index(16'hFFFF);
    load_config(32'h0000_0000, 32'h0004_0000, 16'hFFFF, 3'd1,
                32'h5555_AAAA, 0, 0, 0);
    send_index(16'h7FFF);
    send_index(16'hAAAA);
    load_config(32'h7FFF_FFFF, 32'h8000_0000, 16'd2, 3'd2,
                32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
    send_index(16'd1);
    send_index(16'd2);
  endtask

  task automatic test_random_sweeps();
    logic [15:0] sec;
    int pick;
    for (int phase = 0; phase < 20; phase++) begin
      pick = $urandom_range(0, 3);
      sec = (pick == 0) ? 16'($urandom) : 16'($urandom_range(0, 64));
      if (phase % 5 == 0) sec = (phase % 10 == 0) ? 16'hFFFF : 16'd0;
      if (phase % 3 == 0) begin
        load_config($urandom, $urandom, sec, 3'($urandom),
                    $urandom, $urandom, $urandom, $urandom);
      end else begin
        // modest values keep the Horner chain out of saturation most of the time
        load_config($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000,
                    $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000,
                    sec, 3'($urandom_range(1, 4)),
                    $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000,
                    $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000,
                    $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000,
                    $urandom);
      end
      stall_enable = (phase % 4 != 3);
      for (int i = 0; i < 25; i++) begin
        if ($urandom_range(0, 9) == 0) send_index(16'($urandom));
        else send_index(16'($urandom_range(0, sec + 2)));
      end
    end
    stall_enable = 1'b1;
  endtask

  initial begin
    error_count = 0;
    stall_enable = 1'b1;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_START;
    cfg_data = 32'd0;
    in_valid = 1'b0;
    sample_index = 16'd0;
    m_start = 0;
    m_end = 32'sh0001_0000;
    m_sections = 16'd1;
    m_terms = 3'd1;
    for (int k = 0; k < COEF_REGS; k++) m_coef[k] = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed_extremes();
    test_random_sweeps();
    wait_drain();
    if (error_count == 0 && expected_samples.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
